// ===== design/lcpq_pkg.sv =====
`default_nettype none

package lcpq_pkg;

    localparam int STEP_W = 3;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_EVICT  = 3'd1;
    localparam step_t STEP_SCAN   = 3'd2;
    localparam step_t STEP_APPEND = 3'd3;
    localparam step_t STEP_EMIT   = 3'd4;

    typedef enum logic [2:0] {
        COND_ALWAYS    = 3'd0,
        COND_IN_ACC    = 3'd1,
        COND_ACCEPTED  = 3'd2,
        COND_SCAN_DONE = 3'd3,
        COND_OUT_FREE  = 3'd4
    } cond_t;

    typedef struct packed {
        logic  in_ready;
        logic  evict_chk;
        logic  scan;
        logic  append;
        logic  emit;
        cond_t cond;
        step_t jump_t;
        step_t jump_f;
    } ctrl_word_t;

    typedef struct packed {
        logic in_acc;
        logic accepted;
        logic scan_done;
        logic out_free;
    } cond_flags_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } coord_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RENDER_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Z      = 3'd4;

    localparam logic [6:0] RESET_MAX_ENTRIES  = 7'd45;
    localparam logic [6:0] RESET_RENDER_LIMIT = 7'd45;

    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t w;
        begin
            w = '{in_ready: 1'b0, evict_chk: 1'b0, scan: 1'b0, append: 1'b0, emit: 1'b0,
                  cond: COND_ALWAYS, jump_t: STEP_IDLE, jump_f: STEP_IDLE};
            case (step)
                STEP_IDLE:
                begin
                    w.in_ready = 1'b1;
                    w.cond     = COND_IN_ACC;
                    w.jump_t   = STEP_EVICT;
                    w.jump_f   = STEP_IDLE;
                end
                STEP_EVICT:
                begin
                    w.evict_chk = 1'b1;
                    w.cond      = COND_ACCEPTED;
                    w.jump_t    = STEP_SCAN;
                    w.jump_f    = STEP_EMIT;
                end
                STEP_SCAN:
                begin
                    w.scan   = 1'b1;
                    w.cond   = COND_SCAN_DONE;
                    w.jump_t = STEP_APPEND;
                    w.jump_f = STEP_SCAN;
                end
                STEP_APPEND:
                begin
                    w.append = 1'b1;
                    w.cond   = COND_ALWAYS;
                    w.jump_t = STEP_EMIT;
                    w.jump_f = STEP_EMIT;
                end
                STEP_EMIT:
                begin
                    w.emit   = 1'b1;
                    w.cond   = COND_OUT_FREE;
                    w.jump_t = STEP_IDLE;
                    w.jump_f = STEP_EMIT;
                end
                default:
                begin
                    w.cond   = COND_ALWAYS;
                    w.jump_t = STEP_IDLE;
                    w.jump_f = STEP_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/lcpq_useq.sv =====
`default_nettype none

module lcpq_useq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcpq_pkg::cond_flags_t flags,
    output lcpq_pkg::ctrl_word_t  ctrl
);

    lcpq_pkg::step_t step_reg;
    lcpq_pkg::step_t step_next;
    logic            take;

    assign ctrl = lcpq_pkg::ucode(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            lcpq_pkg::COND_ALWAYS:    take = 1'b1;
            lcpq_pkg::COND_IN_ACC:    take = flags.in_acc;
            lcpq_pkg::COND_ACCEPTED:  take = flags.accepted;
            lcpq_pkg::COND_SCAN_DONE: take = flags.scan_done;
            lcpq_pkg::COND_OUT_FREE:  take = flags.out_free;
            default:                  take = 1'b1;
        endcase
        step_next = take ? ctrl.jump_t : ctrl.jump_f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= lcpq_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/lru_chunk_page_queue_core.sv =====
// LRU queue of resident chunks, one request word in and one result word out.
// The request channel (in_valid, in_stall, chunk_x/y/z) takes a word only while
// the sequencer sits in its idle step; in_stall is high for the rest of the item.
// A request outside 0..limit on any axis gives a result with every field zero.
// Otherwise the oldest entry is evicted when the fill has reached max_entries,
// the queue is searched and compacted in one pass over the memory, and the chunk
// is appended at the back.
// The pass reads one entry per cycle through the single read port, so the
// time that an accepted item takes grows with the fill before the request,
// which is at most QUEUE_DEPTH. A rejected item skips the scan and append
// steps. out_valid rises in the same cycle in which the block is ready again.
// The result sits in an output register: a stall from the receiver holds it
// there while the next request is accepted and processed, and only the final
// step of that next item waits for the register to free up.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// taken; writes to unknown indexes are dropped. Reset empties the queue, loads
// the default limits and leaves no result pending. The queue memory needs no
// clearing pass.
`default_nettype none

module lru_chunk_page_queue_core #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lcpq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lcpq_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [15:0]                   chunk_x,
    input  logic signed [15:0]                   chunk_y,
    input  logic signed [15:0]                   chunk_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 accepted,
    output logic                                 evicted,
    output logic signed [15:0]                   evict_x,
    output logic signed [15:0]                   evict_y,
    output logic signed [15:0]                   evict_z,
    output logic                                 hit,
    output logic [5:0]                           old_position,
    output logic                                 reinsert,
    output logic                                 build
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = (CW > 7) ? CW : 7;

    lcpq_pkg::ctrl_word_t  ctrl;
    lcpq_pkg::cond_flags_t flags;

    logic [6:0]  max_entries_reg;
    logic [6:0]  render_limit_reg;
    logic [14:0] limit_x_reg;
    logic [14:0] limit_y_reg;
    logic [14:0] limit_z_reg;

    lcpq_pkg::coord_t queue_mem [QUEUE_DEPTH];
    lcpq_pkg::coord_t rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    lcpq_pkg::coord_t mem_wdata;
    logic             rd_issue;

    lcpq_pkg::coord_t coord_reg;
    lcpq_pkg::coord_t coord_next;
    lcpq_pkg::coord_t evict_reg;
    lcpq_pkg::coord_t evict_next;
    logic             acc_reg;
    logic             acc_next;
    logic             evicted_reg;
    logic             evicted_next;
    logic             hit_reg;
    logic             hit_next;
    logic [AW-1:0]    pos_reg;
    logic [AW-1:0]    pos_next;
    logic [1:0]       shift_reg;
    logic [1:0]       shift_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    rd_ptr_next;
    logic             rd_vld_reg;
    logic             rd_vld_next;
    logic [AW-1:0]    rd_tag_reg;
    logic [AW-1:0]    rd_tag_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             o_accepted_reg;
    logic             o_evicted_reg;
    lcpq_pkg::coord_t o_evict_reg;
    logic             o_hit_reg;
    logic [5:0]       o_pos_reg;
    logic             o_reinsert_reg;
    logic             o_build_reg;

    logic             in_acc;
    logic             in_ok;
    logic             out_free;
    logic [TW-1:0]    thresh;
    logic             evict_due;
    logic [CW-1:0]    wr_idx;
    logic [CW-1:0]    new_count;
    logic [TW-1:0]    pos_ext;
    logic             load_out;

    lcpq_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = !ctrl.in_ready;
    assign in_acc    = in_valid && ctrl.in_ready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = ctrl.emit && out_free;

    assign in_ok = !chunk_x[15] && (chunk_x[14:0] <= limit_x_reg)
                && !chunk_y[15] && (chunk_y[14:0] <= limit_y_reg)
                && !chunk_z[15] && (chunk_z[14:0] <= limit_z_reg);

    assign thresh = (TW'(max_entries_reg) > TW'(QUEUE_DEPTH)) ? TW'(QUEUE_DEPTH)
                                                             : TW'(max_entries_reg);
    assign evict_due = (count_reg != '0) && (TW'(count_reg) >= thresh);
    assign wr_idx    = CW'(rd_tag_reg) - CW'(shift_reg);
    assign new_count = count_reg - CW'(shift_reg);
    assign pos_ext   = TW'(pos_reg);
    assign rd_issue  = ctrl.scan && (rd_ptr_reg != count_reg);

    always_comb
    begin
        flags.in_acc    = in_acc;
        flags.accepted  = acc_reg;
        flags.scan_done = (rd_ptr_reg == count_reg) && !rd_vld_reg;
        flags.out_free  = out_free;
    end

    always_comb
    begin
        coord_next   = coord_reg;
        evict_next   = evict_reg;
        acc_next     = acc_reg;
        evicted_next = evicted_reg;
        hit_next     = hit_reg;
        pos_next     = pos_reg;
        shift_next   = shift_reg;
        count_next   = count_reg;
        rd_ptr_next  = rd_ptr_reg;
        rd_vld_next  = 1'b0;
        rd_tag_next  = rd_tag_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = coord_reg;

        if (in_acc)
        begin
            coord_next   = {chunk_x, chunk_y, chunk_z};
            acc_next     = in_ok;
            evict_next   = '0;
            evicted_next = 1'b0;
            hit_next     = 1'b0;
            pos_next     = '0;
            shift_next   = 2'd0;
            rd_ptr_next  = '0;
        end

        if (ctrl.evict_chk && acc_reg && evict_due)
        begin
            evicted_next = 1'b1;
            shift_next   = 2'd1;
        end

        if (ctrl.scan)
        begin
            if (rd_issue)
            begin
                rd_vld_next = 1'b1;
                rd_tag_next = rd_ptr_reg[AW-1:0];
                rd_ptr_next = rd_ptr_reg + CW'(1);
            end
            if (rd_vld_reg)
            begin
                if ((rd_tag_reg == '0) && evicted_reg)
                begin
                    evict_next = rd_data_reg;
                end
                else if (!hit_reg && (rd_data_reg == coord_reg))
                begin
                    hit_next   = 1'b1;
                    pos_next   = rd_tag_reg - AW'(evicted_reg);
                    shift_next = shift_reg + 2'd1;
                end
                else if (shift_reg != 2'd0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_idx[AW-1:0];
                    mem_wdata = rd_data_reg;
                end
            end
        end

        if (ctrl.append)
        begin
            if (TW'(new_count) < TW'(QUEUE_DEPTH))
            begin
                mem_we     = 1'b1;
                mem_waddr  = new_count[AW-1:0];
                mem_wdata  = coord_reg;
                count_next = new_count + CW'(1);
            end
            else
            begin
                count_next = new_count;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            queue_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_issue)
        begin
            rd_data_reg <= queue_mem[rd_ptr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg  <= lcpq_pkg::RESET_MAX_ENTRIES;
            render_limit_reg <= lcpq_pkg::RESET_RENDER_LIMIT;
            limit_x_reg      <= '0;
            limit_y_reg      <= '0;
            limit_z_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lcpq_pkg::REG_MAX_ENTRIES:  max_entries_reg  <= cfg_data[6:0];
                lcpq_pkg::REG_RENDER_LIMIT: render_limit_reg <= cfg_data[6:0];
                lcpq_pkg::REG_LIMIT_X:      limit_x_reg      <= cfg_data;
                lcpq_pkg::REG_LIMIT_Y:      limit_y_reg      <= cfg_data;
                lcpq_pkg::REG_LIMIT_Z:      limit_z_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 1'b0;
            evicted_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            pos_reg       <= '0;
            shift_reg     <= 2'd0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            rd_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            evicted_reg   <= evicted_next;
            hit_reg       <= hit_next;
            pos_reg       <= pos_next;
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_vld_reg    <= rd_vld_next;
            rd_tag_reg    <= rd_tag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coord_reg <= coord_next;
        evict_reg <= evict_next;
        if (load_out)
        begin
            o_accepted_reg <= acc_reg;
            o_evicted_reg  <= evicted_reg;
            o_evict_reg    <= evict_reg;
            o_hit_reg      <= hit_reg;
            o_pos_reg      <= pos_ext[5:0];
            o_reinsert_reg <= hit_reg && (pos_ext >= TW'(render_limit_reg));
            o_build_reg    <= acc_reg && !hit_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = o_accepted_reg;
    assign evicted      = o_evicted_reg;
    assign evict_x      = o_evict_reg.x;
    assign evict_y      = o_evict_reg.y;
    assign evict_z      = o_evict_reg.z;
    assign hit          = o_hit_reg;
    assign old_position = o_pos_reg;
    assign reinsert     = o_reinsert_reg;
    assign build        = o_build_reg;

    // The fill never exceeds the memory depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue fill exceeds depth");

    // An accepted request blocks the input until its pass is finished.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a request is in progress");

    // The append step only follows a completed scan of every entry.
    a_append_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.append |-> (rd_ptr_reg == count_reg) && !rd_vld_reg)
        else $error("append before the scan finished");

    // A rejected request reports nothing else.
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |-> (!evicted && !hit && !build && !reinsert))
        else $error("rejected request reports activity");

endmodule

`default_nettype wire
